### design/ntc_thermistor_temperature_core_defines.svh
// assertion helpers for the ntc thermistor core
`ifndef NTC_THERMISTOR_TEMPERATURE_CORE_DEFINES_SVH
`define NTC_THERMISTOR_TEMPERATURE_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define NTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define NTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ntc_pkg.sv
package ntc_pkg;
    localparam int TABLE_ENTRIES = 39;
    localparam int STORED_ENTRIES = 39;
    localparam int LIMIT = (TABLE_ENTRIES > STORED_ENTRIES) ? STORED_ENTRIES : TABLE_ENTRIES;
    localparam int IDX_W = $clog2(LIMIT + 1);

    localparam int RDG_W = 12;
    localparam int REF_W = 20;
    localparam int Q_W   = 36;  // resistance quotient, 1/16 ohm
    localparam int DVS_W = 12;  // full scale minus reading
    localparam int RES_W = 22;  // table entries
    localparam int DIF_W = 20;  // gap between neighboring entries
    localparam int DN_W  = 31;  // rounded interpolation dividend
    localparam int DV_W  = 21;  // rounded interpolation divisor
    localparam int OFF_W = 11;  // interpolation offset, at most 1280
    localparam int TMP_W = 17;

    localparam logic [RDG_W-1:0] FULL_10 = RDG_W'(1023);
    localparam logic [RDG_W-1:0] FULL_12 = RDG_W'(4095);
    localparam logic [REF_W-1:0] REF_RESET = REF_W'(10000);

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_REF  = 1'b1;

    typedef struct packed {
        logic             vld;
        logic             ok;
        logic [IDX_W-1:0] k;
    } t_side;

    function automatic logic [RES_W-1:0] res_tab(input logic [IDX_W-1:0] idx);
        logic [RES_W-1:0] v;
        case (6'(idx))
            6'd0:  v = RES_W'(4939);    6'd1:  v = RES_W'(5478);
            6'd2:  v = RES_W'(6093);    6'd3:  v = RES_W'(6789);
            6'd4:  v = RES_W'(7586);    6'd5:  v = RES_W'(8494);
            6'd6:  v = RES_W'(9538);    6'd7:  v = RES_W'(10736);
            6'd8:  v = RES_W'(12122);   6'd9:  v = RES_W'(13718);
            6'd10: v = RES_W'(15579);   6'd11: v = RES_W'(17728);
            6'd12: v = RES_W'(20256);   6'd13: v = RES_W'(23216);
            6'd14: v = RES_W'(26704);   6'd15: v = RES_W'(30800);
            6'd16: v = RES_W'(35664);   6'd17: v = RES_W'(41424);
            6'd18: v = RES_W'(48352);   6'd19: v = RES_W'(56592);
            6'd20: v = RES_W'(66592);   6'd21: v = RES_W'(78592);
            6'd22: v = RES_W'(93264);   6'd23: v = RES_W'(111056);
            6'd24: v = RES_W'(133024);  6'd25: v = RES_W'(160000);
            6'd26: v = RES_W'(193440);  6'd27: v = RES_W'(234880);
            6'd28: v = RES_W'(287200);  6'd29: v = RES_W'(352480);
            6'd30: v = RES_W'(436000);  6'd31: v = RES_W'(541600);
            6'd32: v = RES_W'(678240);  6'd33: v = RES_W'(852960);
            6'd34: v = RES_W'(1082240); 6'd35: v = RES_W'(1378880);
            6'd36: v = RES_W'(1774400); 6'd37: v = RES_W'(2294400);
            6'd38: v = RES_W'(2998400);
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

### design/ntc_thermistor_temperature_core.sv
// NTC thermistor temperature core. Each item is one converter sample from the
// divider; the result is the temperature in 1/256 C plus a flag that is low when
// the sample is at or above full scale or the resistance falls outside the
// table (temperature then reads 0). The datapath is a fixed pipeline of 52
// stages: a multiply stage, a 36-stage one-bit-per-stage divider for the
// resistance, three table stages, an 11-stage divider for the rounded
// interpolation and the output register. A new item can enter every cycle
// while the output register is free or being taken, one item per clock;
// the pipeline freezes as a whole while an untaken result is held. The user
// must write configuration (twelve_bit_mode at index 0, reference_ohms at index 1)
// only while the pipeline is empty; the block itself does not enforce it.
module ntc_thermistor_temperature_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [19:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [11:0] i_adc_reading,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [16:0] o_temperature_fixed,
    output logic        o_reading_valid
);
    import ntc_pkg::*;

    // configuration registers
    logic             r_twelve_bit_mode;
    logic [REF_W-1:0] r_reference_ohms;

    // global advance: move whenever the output slot is free or being taken
    logic en;

    // stage 0: product and divisor
    logic [RDG_W-1:0] n_full;
    logic             r_s0_vld, r_s0_bad;
    logic [Q_W-1:0]   r_s0_dvd;
    logic [DVS_W-1:0] r_s0_dvs;

    logic             dv_vld, dv_bad;
    logic [Q_W-1:0]   dv_quo;
    t_side            sr_side, od_side;
    logic [DN_W-1:0]  sr_dn;
    logic [DV_W-1:0]  sr_dv;
    logic [OFF_W-1:0] od_off;

    // output register
    logic signed [TMP_W:0] n_temp;
    logic                  r_out_vld, r_out_ok;
    logic [TMP_W-1:0]      r_out_temp;

    assign en = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_twelve_bit_mode <= 1'b0;
            r_reference_ohms  <= REF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE: r_twelve_bit_mode <= i_cfg_data[0];
                CFG_REF:  r_reference_ohms  <= i_cfg_data;
                default:  r_reference_ohms  <= r_reference_ohms;
            endcase
        end
    end

    assign n_full = r_twelve_bit_mode ? FULL_12 : FULL_10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_in_valid;
        end
    end

    // r * 16 = reading * ref * 16 / (full - reading)
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_bad <= (i_adc_reading >= n_full);
            r_s0_dvd <= {Q_W'(i_adc_reading * r_reference_ohms)} << 4;
            r_s0_dvs <= (i_adc_reading >= n_full) ? DVS_W'(1) : DVS_W'(n_full - i_adc_reading);
        end
    end

    ntc_rdiv u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s0_vld),
        .i_bad   (r_s0_bad),
        .i_dvd   (r_s0_dvd),
        .i_dvs   (r_s0_dvs),
        .o_vld   (dv_vld),
        .o_bad   (dv_bad),
        .o_quo   (dv_quo)
    );

    ntc_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (dv_vld),
        .i_bad   (dv_bad),
        .i_r     (dv_quo),
        .o_side  (sr_side),
        .o_dn    (sr_dn),
        .o_dv    (sr_dv)
    );

    ntc_odiv u_odiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (sr_side),
        .i_dn    (sr_dn),
        .i_dv    (sr_dv),
        .o_side  (od_side),
        .o_off   (od_off)
    );

    // entry temperature 150 - 5k degrees, scaled by 256, minus the offset
    assign n_temp = (TMP_W+1)'(38400) - (TMP_W+1)'(od_side.k * 11'd1280)
                    - (TMP_W+1)'(od_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= od_side.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_ok   <= od_side.ok;
            r_out_temp <= od_side.ok ? n_temp[TMP_W-1:0] : '0;
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_reading_valid     = r_out_ok;
    assign o_temperature_fixed = r_out_temp;
endmodule

### design/ntc_rdiv.sv
module ntc_rdiv (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic                 i_bad,
    input  logic [ntc_pkg::Q_W-1:0]   i_dvd,
    input  logic [ntc_pkg::DVS_W-1:0] i_dvs,
    output logic                 o_vld,
    output logic                 o_bad,
    output logic [ntc_pkg::Q_W-1:0]   o_quo
);
    import ntc_pkg::*;

    // one quotient bit per stage, msb first
    logic             r_vld [0:Q_W];
    logic             r_bad [0:Q_W];
    logic [Q_W-1:0]   r_dvd [0:Q_W];
    logic [Q_W-1:0]   r_quo [0:Q_W];
    logic [DVS_W-1:0] r_rem [0:Q_W];
    logic [DVS_W-1:0] r_dvs [0:Q_W];

    always_comb begin
        r_vld[0] = i_vld;
        r_bad[0] = i_bad;
        r_dvd[0] = i_dvd;
        r_quo[0] = '0;
        r_rem[0] = '0;
        r_dvs[0] = i_dvs;
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [DVS_W:0] n_tmp;
        logic           n_ge;
        assign n_tmp = {r_rem[k], r_dvd[k][Q_W-1]};
        assign n_ge  = (n_tmp >= {1'b0, r_dvs[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_bad[k+1] <= r_bad[k];
                r_dvs[k+1] <= r_dvs[k];
                r_dvd[k+1] <= {r_dvd[k][Q_W-2:0], 1'b0};
                r_quo[k+1] <= {r_quo[k][Q_W-2:0], n_ge};
                r_rem[k+1] <= n_ge ? DVS_W'(n_tmp - {1'b0, r_dvs[k]}) : n_tmp[DVS_W-1:0];
            end
        end
    end

    assign o_vld = r_vld[Q_W];
    assign o_bad = r_bad[Q_W];
    assign o_quo = r_quo[Q_W];
endmodule

### design/ntc_search.sv
module ntc_search (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic                  i_bad,
    input  logic [ntc_pkg::Q_W-1:0]  i_r,
    output ntc_pkg::t_side        o_side,
    output logic [ntc_pkg::DN_W-1:0] o_dn,
    output logic [ntc_pkg::DV_W-1:0] o_dv
);
    import ntc_pkg::*;

    // stage 1: compare against every entry
    logic             r1_vld, r1_bad;
    logic [LIMIT-1:0] r1_le;
    logic [RES_W-1:0] r1_r;
    // stage 2: count entries at or below r
    logic             r2_vld, r2_ok;
    logic [IDX_W-1:0] r2_cnt;
    logic [RES_W-1:0] r2_r;
    // stage 3: neighbors and rounded dividend
    logic [LIMIT-1:0] n_le;
    logic [IDX_W-1:0] n_cnt, n_k;
    logic [RES_W-1:0] n_lo, n_hi;
    logic [DIF_W-1:0] n_dif, n_den;
    logic [DN_W-1:0]  n_dn;
    t_side            r3_side;
    logic [DN_W-1:0]  r3_dn;
    logic [DV_W-1:0]  r3_dv;

    always_comb begin
        for (int j = 0; j < LIMIT; j++) begin
            n_le[j] = ({{(Q_W-RES_W){1'b0}}, res_tab(IDX_W'(j))} <= i_r);
        end
    end

    // table is increasing, so the first entry above r sits at the count of those at or below
    assign n_cnt = IDX_W'($countones(r1_le));
    assign n_k   = r2_cnt - IDX_W'(1);
    assign n_lo  = res_tab(n_k);
    assign n_hi  = res_tab(r2_cnt);
    assign n_dif = DIF_W'(r2_r - n_lo);
    assign n_den = DIF_W'(n_hi - n_lo);
    // 2 * 1280 * dif + den, so a plain divide by 2 * den rounds half up
    assign n_dn  = DN_W'({n_dif, 11'b0}) + DN_W'({n_dif, 9'b0}) + DN_W'(n_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld       <= 1'b0;
            r2_vld       <= 1'b0;
            r3_side.vld  <= 1'b0;
        end else if (i_en) begin
            r1_vld       <= i_vld;
            r2_vld       <= r1_vld;
            r3_side.vld  <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_bad     <= i_bad;
            r1_le      <= n_le;
            r1_r       <= i_r[RES_W-1:0];
            r2_ok      <= !r1_bad && (n_cnt != '0) && (n_cnt < IDX_W'(LIMIT));
            r2_cnt     <= n_cnt;
            r2_r       <= r1_r;
            r3_side.ok <= r2_ok && (n_den != '0);
            r3_side.k  <= n_k;
            r3_dn      <= r2_ok ? n_dn : '0;
            r3_dv      <= r2_ok ? {n_den, 1'b0} : DV_W'(2);
        end
    end

    assign o_side = r3_side;
    assign o_dn   = r3_dn;
    assign o_dv   = r3_dv;
endmodule

### design/ntc_odiv.sv
module ntc_odiv (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  ntc_pkg::t_side           i_side,
    input  logic [ntc_pkg::DN_W-1:0] i_dn,
    input  logic [ntc_pkg::DV_W-1:0] i_dv,
    output ntc_pkg::t_side           o_side,
    output logic [ntc_pkg::OFF_W-1:0] o_off
);
    import ntc_pkg::*;

    // quotient stays below 2^OFF_W, so the top bits start as the remainder
    t_side            r_side [0:OFF_W];
    logic [DV_W-1:0]  r_rem  [0:OFF_W];
    logic [OFF_W-1:0] r_low  [0:OFF_W];
    logic [DV_W-1:0]  r_dv   [0:OFF_W];
    logic [OFF_W-1:0] r_quo  [0:OFF_W];

    always_comb begin
        r_side[0] = i_side;
        r_rem[0]  = DV_W'(i_dn[DN_W-1:OFF_W]);
        r_low[0]  = i_dn[OFF_W-1:0];
        r_dv[0]   = i_dv;
        r_quo[0]  = '0;
    end

    for (genvar k = 0; k < OFF_W; k++) begin : g_stage
        logic [DV_W:0] n_tmp;
        logic          n_ge;
        assign n_tmp = {r_rem[k], r_low[k][OFF_W-1]};
        assign n_ge  = (n_tmp >= {1'b0, r_dv[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k+1].vld <= 1'b0;
            end else if (i_en) begin
                r_side[k+1].vld <= r_side[k].vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1].ok <= r_side[k].ok;
                r_side[k+1].k  <= r_side[k].k;
                r_dv[k+1]      <= r_dv[k];
                r_low[k+1]     <= {r_low[k][OFF_W-2:0], 1'b0};
                r_quo[k+1]     <= {r_quo[k][OFF_W-2:0], n_ge};
                r_rem[k+1]     <= n_ge ? DV_W'(n_tmp - {1'b0, r_dv[k]}) : n_tmp[DV_W-1:0];
            end
        end
    end

    assign o_side = r_side[OFF_W];
    assign o_off  = r_quo[OFF_W];
endmodule

### design/ntc_chk.sv
`include "ntc_thermistor_temperature_core_defines.svh"

module ntc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic signed [16:0] o_temperature_fixed,
    input logic        o_reading_valid
);
    `NTC_ASSERT_NOW(a_nan_zero, i_clk, i_rst_n, o_out_valid && !o_reading_valid, o_temperature_fixed == 17'sd0, "invalid item with nonzero temperature")
    `NTC_ASSERT_NOW(a_range, i_clk, i_rst_n, o_out_valid && o_reading_valid, (o_temperature_fixed >= -17'sd10240) && (o_temperature_fixed <= 17'sd38400), "temperature out of table range")
    `NTC_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !o_out_valid || i_out_ready, o_in_ready, "input stalled with free output")
    `NTC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_temperature_fixed) && $stable(o_reading_valid), "stalled result changed")
endmodule

bind ntc_thermistor_temperature_core ntc_chk u_ntc_chk (.*);

### tb/ntc_thermistor_temperature_core_tb.sv
`timescale 1ns / 100ps

module ntc_thermistor_temperature_core_tb;
    import ntc_pkg::*;

    // table span the core searches, capped at the stored table size
    localparam int N_ENT = (TABLE_ENTRIES > 39) ? 39 : TABLE_ENTRIES;
    localparam int unsigned OHM16 [39] = '{
        4939, 5478, 6093, 6789, 7586, 8494, 9538, 10736,
        12122, 13718, 15579, 17728, 20256, 23216, 26704, 30800,
        35664, 41424, 48352, 56592, 66592, 78592, 93264, 111056,
        133024, 160000, 193440, 234880, 287200, 352480, 436000, 541600,
        678240, 852960, 1082240, 1378880, 1774400, 2294400, 2998400
    };
    localparam int DRAIN_CYCLES = 70;       // pipeline is 52 deep
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 200;

    typedef struct {
        logic signed [TMP_W-1:0] temp;
        logic                    ok;
    } t_temp;

    typedef struct {
        logic             mode;
        logic [REF_W-1:0] ohms;
        logic [RDG_W-1:0] rdg;
        bit               typed;        // expected value written in the row
        logic signed [TMP_W-1:0] temp;
        logic             ok;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_idx;
    logic [19:0]         i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [11:0]         i_adc_reading;
    logic                o_out_valid;
    logic                i_out_ready;
    logic signed [16:0]  o_temperature_fixed;
    logic                o_reading_valid;

    ntc_thermistor_temperature_core u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_adc_reading       (i_adc_reading),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_temperature_fixed (o_temperature_fixed),
        .o_reading_valid     (o_reading_valid)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // shadow copy of the configuration registers
    logic             cur_mode;
    logic [REF_W-1:0] cur_ohms;

    t_temp temp_q[$];           // temperatures still owed by the core
    int    n_err;
    int    n_items;
    int    n_results;
    int    n_valid_results;
    int    n_cycles;
    bit    hold_req;
    bit    no_idle;

    // temperature the core should report for one sample
    function automatic t_temp calc_temp(logic [RDG_W-1:0] rdg);
        t_temp             res;
        longint unsigned   full, r16, lo, den, num, off;
        longint            t;
        int                i;
        res.temp = '0;
        res.ok   = 1'b0;
        full = cur_mode ? 64'd4095 : 64'd1023;
        if (longint'(rdg) < full) begin
            r16 = (longint'(rdg) * longint'(cur_ohms) * 16) / (full - longint'(rdg));
            i = 0;
            while (i < N_ENT && longint'(OHM16[i]) <= r16)
                i++;
            if (i != 0 && i < N_ENT) begin
                lo  = OHM16[i-1];
                den = longint'(OHM16[i]) - lo;
                if (den != 0) begin
                    num = (r16 - lo) * 1280;
                    // round half up
                    off = (2 * num + den) / (2 * den);
                    t = (150 - 5 * longint'(i - 1)) * 256 - longint'(off);
                    res.temp = TMP_W'(t);
                    res.ok   = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // drive one register write; the caller drops the write enable afterwards
    task automatic write_reg(input logic idx, input logic [19:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_MODE)
            cur_mode = val[0];
        else
            cur_ohms = val;
    endtask

    // stop offering, wait for every owed result, then let the pipeline go quiet
    task automatic drain;
        i_in_valid <= 1'b0;
        while (temp_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_cfg(input logic mode, input logic [REF_W-1:0] ohms);
        if (mode != cur_mode || ohms != cur_ohms) begin
            drain();
            write_reg(CFG_MODE, {19'd0, mode});
            write_reg(CFG_REF, ohms);
            i_cfg_we <= 1'b0;
        end
    endtask

    // offer one item, optionally preceded by an idle gap, and wait for accept
    task automatic send_item(input logic [RDG_W-1:0] rdg, input t_temp want);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 2) == 0)
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                : $urandom_range(1, 3);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_adc_reading <= rdg;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        temp_q.push_back(want);
        n_items++;
    endtask

    // pick a sample, mostly below full scale so the table gets exercised
    function automatic logic [RDG_W-1:0] pick_rdg;
        int full;
        full = cur_mode ? 4095 : 1023;
        case ($urandom_range(0, 9))
            0:       return RDG_W'($urandom_range(0, 4095));
            1:       return RDG_W'($urandom_range(full - 8, full));
            default: return RDG_W'($urandom_range(0, full - 1));
        endcase
    endfunction

    // directed rows: reset config, full-scale edges, zero reading, zero and
    // extreme divider resistors, samples across the table
    t_row dir_rows[] = '{
        '{1'b0, 20'd10000,   12'd0,    1'b1, 17'sd0, 1'b0},
        '{1'b0, 20'd10000,   12'd1023, 1'b1, 17'sd0, 1'b0},
        '{1'b0, 20'd10000,   12'd4095, 1'b1, 17'sd0, 1'b0},
        '{1'b0, 20'd10000,   12'd1022, 1'b1, 17'sd0, 1'b0},
        '{1'b0, 20'd10000,   12'd512,  1'b0, 17'sd0, 1'b0},
        '{1'b0, 20'd10000,   12'd300,  1'b0, 17'sd0, 1'b0},
        '{1'b0, 20'd10000,   12'd900,  1'b0, 17'sd0, 1'b0},
        '{1'b0, 20'd10000,   12'd40,   1'b0, 17'sd0, 1'b0},
        '{1'b0, 20'd0,       12'd500,  1'b1, 17'sd0, 1'b0},
        '{1'b0, 20'd0,       12'd1,    1'b1, 17'sd0, 1'b0},
        '{1'b1, 20'd10000,   12'd4095, 1'b1, 17'sd0, 1'b0},
        '{1'b1, 20'd10000,   12'd4094, 1'b1, 17'sd0, 1'b0},
        '{1'b1, 20'd10000,   12'd1,    1'b1, 17'sd0, 1'b0},
        '{1'b1, 20'd10000,   12'd2048, 1'b0, 17'sd0, 1'b0},
        '{1'b1, 20'd10000,   12'd3600, 1'b0, 17'sd0, 1'b0},
        '{1'b1, 20'd10000,   12'd400,  1'b0, 17'sd0, 1'b0},
        '{1'b1, 20'd1000000, 12'd1,    1'b0, 17'sd0, 1'b0},
        '{1'b1, 20'd1000000, 12'd10,   1'b0, 17'sd0, 1'b0},
        '{1'b1, 20'd1000000, 12'd100,  1'b0, 17'sd0, 1'b0},
        '{1'b0, 20'd1000000, 12'd1022, 1'b1, 17'sd0, 1'b0},
        '{1'b0, 20'd1000000, 12'd3,    1'b0, 17'sd0, 1'b0},
        '{1'b0, 20'd1,       12'd1000, 1'b0, 17'sd0, 1'b0},
        '{1'b0, 20'd1,       12'd1022, 1'b0, 17'sd0, 1'b0},
        '{1'b1, 20'd1,       12'd4094, 1'b0, 17'sd0, 1'b0}
    };

    // stimulus
    initial begin
        t_temp            want;
        logic [REF_W-1:0] ohms;
        logic             mode;
        n_err = 0;
        n_items = 0;
        hold_req = 0;
        no_idle = 0;
        cur_mode = 1'b0;
        cur_ohms = REF_RESET;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_MODE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_adc_reading = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, first rows run on the reset configuration
        foreach (dir_rows[k]) begin
            set_cfg(dir_rows[k].mode, dir_rows[k].ohms);
            if (dir_rows[k].typed) begin
                want.temp = dir_rows[k].temp;
                want.ok   = dir_rows[k].ok;
            end else begin
                want = calc_temp(dir_rows[k].rdg);
            end
            send_item(dir_rows[k].rdg, want);
        end

        // random phases, extremes of the divider first
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       begin mode = 1'b0; ohms = 20'd10000;   end
                1:       begin mode = 1'b1; ohms = 20'd1;       end
                2:       begin mode = 1'b1; ohms = 20'd1000000; end
                3:       begin mode = 1'b0; ohms = 20'd1000000; end
                4:       begin mode = 1'b0; ohms = 20'd1;       end
                default: begin
                    mode = 1'($urandom_range(0, 1));
                    ohms = REF_W'($urandom_range(1, 1000000));
                end
            endcase
            // nudge so each phase really rewrites both registers
            if (mode == cur_mode && ohms == cur_ohms)
                cur_ohms = ~ohms;
            set_cfg(mode, ohms);
            no_idle = (ph == 2 || ph == 5);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off while items keep coming
                if (ph == 2 && n == 40)
                    hold_req = 1;
                logic_rdg: begin
                    logic [RDG_W-1:0] rdg;
                    rdg = pick_rdg();
                    send_item(rdg, calc_temp(rdg));
                end
            end
        end

        drain();
        $display("%0d samples over %0d configurations, %0d results (%0d in table range)",
                 n_items, RAND_PHASES + 7, n_results, n_valid_results);
        $display("including full-scale, zero-resistor and out-of-table cases");
        if (n_err == 0)
            $display("ntc_thermistor_temperature_core_tb: done, clean");
        else
            $display("ntc_thermistor_temperature_core_tb: done, errors");
        $finish;
    end

    // receiver: random stalls, one long hold-off, and the result check
    int  stall_cnt;
    int  hold_cnt;
    bit  hold_done;
    initial begin
        i_out_ready = 1'b0;
        stall_cnt = 0;
        hold_cnt = 0;
        hold_done = 0;
        n_results = 0;
        n_valid_results = 0;
    end

    always @(posedge i_clk) begin
        t_temp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (temp_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result: temp %0d ok %0b",
                             o_temperature_fixed, o_reading_valid);
            end else begin
                want = temp_q.pop_front();
                if (want.ok)
                    n_valid_results++;
                if (o_temperature_fixed !== want.temp || o_reading_valid !== want.ok) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: temp exp %0d got %0d, ok exp %0b got %0b",
                                 want.temp, o_temperature_fixed, want.ok, o_reading_valid);
                end
            end
        end
        // ready for the next cycle
        if (hold_req && !hold_done) begin
            hold_done <= 1;
            hold_cnt  <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            i_out_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            stall_cnt <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 2);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // watchdog
    initial n_cycles = 0;
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("ntc_thermistor_temperature_core_tb: done, errors");
            $finish;
        end
    end

endmodule

### sim.f
+incdir+design
design/ntc_pkg.sv
design/ntc_rdiv.sv
design/ntc_search.sv
design/ntc_odiv.sv
design/ntc_thermistor_temperature_core.sv
design/ntc_chk.sv
tb/ntc_thermistor_temperature_core_tb.sv
